[hdl/i2d_pkg.sv]
`default_nettype none

package i2d_pkg;

  localparam int unsigned ValueWidth = 64;
  // 2^63 has 19 decimal digits, the largest magnitude a signed 64-bit value gives
  localparam int unsigned NumDigits  = 19;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = 6;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  localparam logic [CntWidth-1:0] ShiftCntInit = CntWidth'(ValueWidth - 1);
  localparam logic [CntWidth-1:0] DigitCntInit = CntWidth'(NumDigits - 1);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigit
  } state_e;

endpackage

`default_nettype wire

[hdl/int64_to_decimal_text.sv]
`default_nettype none

// Channel  Dir  Handshake                 Payload
// -------  ---  ------------------------  -------------------------------------
// in       in   in_valid_i / in_ready_o   value_i[63:0] (signed)
// out      out  out_valid_o / out_ready_i text_char_o[7:0], last_char_o
//
// One transaction runs through an idle state, 64 double-dabble shift steps through
// the shared add-3 / shift unit, s leading-zero digits dropped one per cycle (0..18)
// until the first digit is found, and c characters (1..20), one per cycle while the
// output is not stalled. Reset clears the state machine and the output valid; data
// registers are not reset. A stalled output holds its character and stalls the sign
// and digit states; a new value is taken once the last character is registered.
module int64_to_decimal_text (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       text_char_o,
  output logic             last_char_o
);
  import i2d_pkg::*;

  state_e state_q, state_d;

  logic [ValueWidth-1:0] bin_q, bin_d;   // magnitude, shifted out MSB first
  logic [BcdWidth-1:0]   bcd_q, bcd_d;   // BCD accumulator, top digit most significant
  logic [CntWidth-1:0]   cnt_q, cnt_d;   // shift steps left minus one, then digits left minus one
  logic                  neg_q, neg_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;

  logic                  in_fire;
  logic                  slot_free;
  logic [BcdWidth-1:0]   bcd_adj;
  logic [3:0]            top_digit;
  logic [ValueWidth-1:0] mag;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign top_digit   = bcd_q[BcdWidth-1 -: 4];
  // unsigned magnitude: also correct for the most negative value
  assign mag         = value_i[ValueWidth-1] ? (~value_i + ValueWidth'(1)) : value_i;

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

  // Shared add-3 unit: every BCD digit of 5 or more gets 3 added before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) state_d = StConv;
      end
      StConv: begin
        if (cnt_q == '0) state_d = StSkip;
      end
      StSkip: begin
        if (top_digit != 4'd0 || cnt_q == '0) begin
          state_d = neg_q ? StSign : StDigit;
        end
      end
      StSign: begin
        if (slot_free) state_d = StDigit;
      end
      StDigit: begin
        if (slot_free && cnt_q == '0) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and output register
  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          bin_d = mag;
          bcd_d = '0;
          cnt_d = ShiftCntInit;
          neg_d = value_i[ValueWidth-1];
        end
      end
      StConv: begin
        bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
        bin_d = {bin_q[ValueWidth-2:0], 1'b0};
        cnt_d = (cnt_q == '0) ? DigitCntInit : cnt_q - CntWidth'(1);
      end
      StSkip: begin
        // drop leading zeros, keeping at least the units digit
        if (top_digit == 4'd0 && cnt_q != '0) begin
          bcd_d = {bcd_q[BcdWidth-5:0], 4'd0};
          cnt_d = cnt_q - CntWidth'(1);
        end
      end
      StSign: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = CharMinus;
          last_d      = 1'b0;
        end
      end
      StDigit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = CharZero + {4'd0, top_digit};
          last_d      = (cnt_q == '0);
          bcd_d       = {bcd_q[BcdWidth-5:0], 4'd0};
          if (cnt_q != '0) cnt_d = cnt_q - CntWidth'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire
